### sv/cpseg_pkg.sv
// ----------------------------------------------------------------------------
// cpseg_pkg
// Shared types, widths and helpers of the nearest-point-on-segments block.
// ----------------------------------------------------------------------------
package cpseg_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int COORD_W = 32;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int DEN_W   = PROD_W + 2;
  localparam int NUM_W   = PROD_W + 3;
  localparam int CNT_W   = $clog2(FRACTION_BITS + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      last_segment;
  } cpseg_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] nearest_x;
    logic signed [COORD_W-1:0] nearest_y;
  } cpseg_out_t;

  typedef struct packed {
    logic                      busy;
    logic                      valid;
    logic signed [COORD_W-1:0] ix;
    logic signed [COORD_W-1:0] iy;
    logic [PROD_W-1:0]         sq_dist;
  } cpseg_res_t;

  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic [COORD_W:0] ab;
    logic [COORD_W:0] ba;
    ab = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    ba = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    return (a < b) ? ba[COORD_W-1:0] : ab[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] lerp(input logic signed [COORD_W-1:0] s,
                                                     input logic neg,
                                                     input logic [PROD_W-1:0] p);
    logic [COORD_W-1:0] m;
    logic [COORD_W:0]   r;
    m = p[FRACTION_BITS +: COORD_W];
    r = neg ? ({s[COORD_W-1], s} - {1'b0, m}) : ({s[COORD_W-1], s} + {1'b0, m});
    return r[COORD_W-1:0];
  endfunction

endpackage

### sv/closest_point_on_segments_top.sv
// ----------------------------------------------------------------------------
// closest_point_on_segments_top
// Nearest point to a query point over a set of segments, one segment a word.
// ----------------------------------------------------------------------------
// Each input word carries the query point, one segment and a last flag. A
// segment whose projection falls inside it passes through the restoring
// divider, one quotient bit a cycle; one that clamps to an endpoint skips the
// divider. The sequencer runs all products on one shared 32x32 multiplier.
// in_stall stays high while a segment is in work. The word with last_segment
// set yields one output word with the nearest point kept over the set (zero,
// zero if none was kept); the output register lets the next segment start
// while that word waits.
module closest_point_on_segments_top
  import cpseg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  cpseg_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output cpseg_out_t out_data
);

  cpseg_res_t                res;
  logic                      accept;
  logic                      take;
  logic                      last_seg;
  logic [PROD_W-1:0]         best_dist;
  logic signed [COORD_W-1:0] best_x, best_y;
  logic                      upd;
  logic signed [COORD_W-1:0] best_x_next, best_y_next;

  assign in_stall = res.busy;
  assign accept   = in_valid && !in_stall;
  assign take     = res.valid && !(last_seg && out_valid && out_stall);

  assign upd         = res.sq_dist < best_dist;
  assign best_x_next = upd ? res.ix : best_x;
  assign best_y_next = upd ? res.iy : best_y;

  cpseg_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .item  (in_data),
    .take  (take),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seg  <= 1'b0;
      out_valid <= 1'b0;
      best_dist <= '1;
      best_x    <= '0;
      best_y    <= '0;
    end else begin
      if (accept) begin
        last_seg <= in_data.last_segment;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (last_seg) begin
          out_valid <= 1'b1;
          best_dist <= '1;
          best_x    <= '0;
          best_y    <= '0;
        end else if (upd) begin
          best_dist <= res.sq_dist;
          best_x    <= res.ix;
          best_y    <= res.iy;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_seg) begin
      out_data.nearest_x <= best_x_next;
      out_data.nearest_y <= best_y_next;
    end
  end

endmodule

### sv/cpseg_mul.sv
// ----------------------------------------------------------------------------
// cpseg_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module cpseg_mul
  import cpseg_pkg::*;
(
  input  logic               clk,
  input  logic [COORD_W-1:0] a,
  input  logic [COORD_W-1:0] b,
  output logic [PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### sv/cpseg_core.sv
// ----------------------------------------------------------------------------
// cpseg_core
// Sequencer and datapath for one segment: projection terms on the shared
// multiplier, restoring division for the segment parameter, interpolation
// and squared distance.
// ----------------------------------------------------------------------------
module cpseg_core
  import cpseg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cpseg_in_t  item,
  input  logic       take,
  output cpseg_res_t res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_LERP = 3'd4;
  localparam logic [2:0] S_MAG  = 3'd5;
  localparam logic [2:0] S_SQ   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]              state;
  logic [CNT_W-1:0]        cnt;

  logic signed [COORD_W-1:0] qx, qy, sx, sy, ex, ey;
  logic [COORD_W-1:0]      mag_ax, mag_ay, mag_dx, mag_dy;
  logic                    sg_ax, sg_ay, sg_dx, sg_dy;
  logic [DEN_W-1:0]        den;
  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        rmd;
  logic [FRACTION_BITS-1:0] u;
  logic signed [COORD_W-1:0] ix, iy;
  logic [PROD_W-1:0]       sq_dist;

  logic [COORD_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]       p;
  logic [NUM_W-1:0]        p_ext;
  logic [DEN_W:0]          shifted;
  logic                    q_bit;
  logic                    num_pos;
  logic                    num_ge;
  logic [PROD_W:0]         dist_sum;

  cpseg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  always_comb begin
    mul_a = mag_ax;
    mul_b = mag_ax;
    unique case (state)
      S_MUL: begin
        unique case (cnt)
          CNT_W'(1): begin mul_a = mag_ay; mul_b = mag_ay; end
          CNT_W'(2): begin mul_a = mag_dx; mul_b = mag_ax; end
          CNT_W'(3): begin mul_a = mag_dy; mul_b = mag_ay; end
          default:   begin mul_a = mag_ax; mul_b = mag_ax; end
        endcase
      end
      S_LERP: begin
        mul_a = (cnt == CNT_W'(0)) ? mag_ax : mag_ay;
        mul_b = COORD_W'(u);
      end
      S_SQ: begin
        mul_a = (cnt == CNT_W'(0)) ? mag_dx : mag_dy;
        mul_b = mul_a;
      end
      default: begin
        mul_a = mag_ax;
        mul_b = mag_ax;
      end
    endcase
  end

  assign p_ext    = NUM_W'(p);
  assign shifted  = {rmd, 1'b0};
  assign q_bit    = shifted >= {1'b0, den};
  assign num_pos  = !num[NUM_W-1] && (num != '0);
  assign num_ge   = num[DEN_W-1:0] >= den;
  assign dist_sum = {1'b0, sq_dist} + {1'b0, p};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MUL;
            cnt   <= '0;
          end
        end
        S_MUL: begin
          if (cnt == CNT_W'(4)) begin
            state <= S_DEC;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_DEC: begin
          state <= (num_pos && !num_ge) ? S_DIV : S_MAG;
          cnt   <= '0;
        end
        S_DIV: begin
          if (cnt == CNT_W'(FRACTION_BITS - 1)) begin
            state <= S_LERP;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_LERP: begin
          if (cnt == CNT_W'(2)) begin
            state <= S_MAG;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_MAG: begin
          state <= S_SQ;
          cnt   <= '0;
        end
        S_SQ: begin
          if (cnt == CNT_W'(2)) begin
            state <= S_DONE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          qx     <= item.query_x;
          qy     <= item.query_y;
          sx     <= item.start_x;
          sy     <= item.start_y;
          ex     <= item.end_x;
          ey     <= item.end_y;
          mag_ax <= abs_diff(item.end_x, item.start_x);
          mag_ay <= abs_diff(item.end_y, item.start_y);
          mag_dx <= abs_diff(item.query_x, item.start_x);
          mag_dy <= abs_diff(item.query_y, item.start_y);
          sg_ax  <= item.end_x < item.start_x;
          sg_ay  <= item.end_y < item.start_y;
          sg_dx  <= item.query_x < item.start_x;
          sg_dy  <= item.query_y < item.start_y;
        end
      end
      S_MUL: begin
        unique case (cnt)
          CNT_W'(1): den <= DEN_W'(p);
          CNT_W'(2): den <= den + DEN_W'(p);
          CNT_W'(3): num <= (sg_dx ^ sg_ax) ? (NUM_W'(0) - p_ext) : p_ext;
          CNT_W'(4): num <= (sg_dy ^ sg_ay) ? (num - p_ext) : (num + p_ext);
          default: ;
        endcase
      end
      S_DEC: begin
        rmd <= num[DEN_W-1:0];
        u   <= '0;
        if (!num_pos) begin
          ix <= sx;
          iy <= sy;
        end else if (num_ge) begin
          ix <= ex;
          iy <= ey;
        end
      end
      S_DIV: begin
        rmd <= q_bit ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
        u   <= {u[FRACTION_BITS-2:0], q_bit};
      end
      S_LERP: begin
        if (cnt == CNT_W'(1)) begin
          ix <= lerp(sx, sg_ax, p);
        end
        if (cnt == CNT_W'(2)) begin
          iy <= lerp(sy, sg_ay, p);
        end
      end
      S_MAG: begin
        mag_dx <= abs_diff(ix, qx);
        mag_dy <= abs_diff(iy, qy);
      end
      S_SQ: begin
        if (cnt == CNT_W'(1)) begin
          sq_dist <= p;
        end
        if (cnt == CNT_W'(2)) begin
          sq_dist <= dist_sum[PROD_W] ? '1 : dist_sum[PROD_W-1:0];
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign res.busy    = state != S_IDLE;
  assign res.valid   = state == S_DONE;
  assign res.ix      = ix;
  assign res.iy      = iy;
  assign res.sq_dist = sq_dist;

endmodule
